// ===== sv/frame_receiver_with_checksum_top_macros.svh =====
// Assertion macros for the frame receiver.
`ifndef FRAME_RECEIVER_WITH_CHECKSUM_TOP_MACROS_SVH
`define FRAME_RECEIVER_WITH_CHECKSUM_TOP_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define FRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define FRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/frc_pkg.sv =====
// Shared types, codes and the checksum mix function of the frame receiver.
package frc_pkg;

  localparam int unsigned SumW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TmoW  = 8;
  localparam int unsigned RtyW  = 4;
  localparam int unsigned EvW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [EvW-1:0] event_t;
  localparam event_t EvHeader  = 3'd0;
  localparam event_t EvPayload = 3'd1;
  localparam event_t EvAccept  = 3'd2;
  localparam event_t EvRetry   = 3'd3;
  localparam event_t EvGiveUp  = 3'd4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegSeed    = 2'd0;
  localparam cfg_idx_t RegTimeout = 2'd1;
  localparam cfg_idx_t RegRetry   = 2'd2;

  localparam logic [SumW-1:0]  SeedReset    = 16'h5555;
  localparam logic [TmoW-1:0]  TimeoutReset = 8'h40;
  localparam logic [RtyW-1:0]  RetryReset   = 4'd5;
  localparam logic [ByteW-1:0] AckByte      = 8'd6;
  localparam logic [ByteW-1:0] NakByte      = 8'd21;

  // rotate left by one, then add the byte, modulo 2^16
  function automatic logic [SumW-1:0] mix_byte(input logic [SumW-1:0] sum,
                                               input logic [ByteW-1:0] b);
    logic [SumW-1:0] rot;
    rot = {sum[SumW-2:0], sum[SumW-1]};
    return rot + {{(SumW-ByteW){1'b0}}, b};
  endfunction

endpackage

// ===== sv/frame_receiver_with_checksum_top.sv =====
// Frame receiver: deframes kind/length/offset/payload/checksum with timeout and retries.
//
//  channel | dir | handshake                   | word
//  --------+-----+-----------------------------+-------------------------------------
//  in      | in  | in_valid_i / in_stall_o     | action_i, rx_byte_i
//  out     | out | out_valid_o / out_stall_i   | event_res_o .. last_o
//  cfg     | in  | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One word per cycle while in_stall_o is low; its result shows in the output register on the next cycle.
// The state update and result are one short combinational pass from state and input.
// in_stall_o is high only while a result sits in the output register and is stalled.
// Reset loads the register defaults and waits for a kind byte; no clearing pass.
module frame_receiver_with_checksum_top
  import frc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [EvW-1:0]      event_res_o,
  output logic [ByteW-1:0]    packet_kind_o,
  output logic [ByteW-1:0]    payload_length_o,
  output logic [SumW-1:0]     frame_offset_o,
  output logic [ByteW-1:0]    byte_index_o,
  output logic [ByteW-1:0]    payload_byte_o,
  output logic [ByteW-1:0]    reply_byte_o,
  output logic                last_o
);

  `include "frame_receiver_with_checksum_top_macros.svh"

  typedef enum logic [2:0] {
    PH_KIND   = 3'd0,
    PH_LEN    = 3'd1,
    PH_OFS_LO = 3'd2,
    PH_OFS_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHK_LO = 3'd5,
    PH_CHK_HI = 3'd6
  } phase_e;

  typedef struct packed {
    logic [EvW-1:0]   ev;
    logic [ByteW-1:0] kind;
    logic [ByteW-1:0] len;
    logic [SumW-1:0]  ofs;
    logic [ByteW-1:0] idx;
    logic [ByteW-1:0] val;
    logic [ByteW-1:0] reply;
    logic             last;
  } result_t;

  logic [SumW-1:0]  seed_q;
  logic [TmoW-1:0]  timeout_q;
  logic [RtyW-1:0]  retry_q;

  phase_e           phase_q, phase_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] kind_q, kind_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] ofs_lo_q, ofs_lo_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] chk_lo_q, chk_lo_d;
  logic [RtyW-1:0]  fail_q, fail_d;
  logic [TmoW-1:0]  deadline_q, deadline_d;

  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  result_t          res;
  logic             res_valid;

  logic             in_accept;
  logic             in_frame;
  logic             fail;
  logic [TmoW-1:0]  dl_dec;
  logic [RtyW:0]    fail_next;
  logic [ByteW-1:0] count_inc;
  logic [SumW-1:0]  chk_word;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_frame   = (phase_q != PH_KIND);
  assign dl_dec     = deadline_q - {{(TmoW-1){1'b0}}, (deadline_q != '0)};
  assign fail_next  = {1'b0, fail_q} + {{RtyW{1'b0}}, 1'b1};
  assign count_inc  = count_q + 8'd1;
  assign chk_word   = {rx_byte_i, chk_lo_q};

  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    kind_d     = kind_q;
    len_d      = len_q;
    ofs_lo_d   = ofs_lo_q;
    count_d    = count_q;
    chk_lo_d   = chk_lo_q;
    fail_d     = fail_q;
    deadline_d = deadline_q;
    res_valid  = 1'b0;
    fail       = 1'b0;
    res        = '{ev: EvHeader, kind: kind_q, len: len_q, ofs: '0, idx: '0,
                   val: '0, reply: '0, last: 1'b0};

    if (in_accept) begin
      if (action_i) begin
        if (in_frame) begin
          deadline_d = dl_dec;
          if (dl_dec == '0) begin
            fail = 1'b1;
          end
        end
      end else begin
        case (phase_q)
          PH_LEN: begin
            len_d   = rx_byte_i;
            sum_d   = mix_byte(sum_q, rx_byte_i);
            phase_d = PH_OFS_LO;
          end
          PH_OFS_LO: begin
            ofs_lo_d = rx_byte_i;
            sum_d    = mix_byte(sum_q, rx_byte_i);
            phase_d  = PH_OFS_HI;
          end
          PH_OFS_HI: begin
            sum_d     = mix_byte(sum_q, rx_byte_i);
            count_d   = '0;
            phase_d   = (len_q == '0) ? PH_CHK_LO : PH_DATA;
            res_valid = 1'b1;
            res.ev    = EvHeader;
            res.ofs   = {rx_byte_i, ofs_lo_q};
          end
          PH_DATA: begin
            sum_d     = mix_byte(sum_q, rx_byte_i);
            count_d   = count_inc;
            if (count_inc >= len_q) begin
              phase_d = PH_CHK_LO;
            end
            res_valid = 1'b1;
            res.ev    = EvPayload;
            res.idx   = count_q;
            res.val   = rx_byte_i;
          end
          PH_CHK_LO: begin
            chk_lo_d = rx_byte_i;
            phase_d  = PH_CHK_HI;
          end
          PH_CHK_HI: begin
            if (deadline_q != '0 && chk_word == sum_q) begin
              fail_d     = '0;
              res_valid  = 1'b1;
              res.ev     = EvAccept;
              res.reply  = AckByte;
              res.last   = 1'b1;
              phase_d    = PH_KIND;
              deadline_d = '0;
              sum_d      = seed_q;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            kind_d     = rx_byte_i;
            len_d      = '0;
            ofs_lo_d   = '0;
            count_d    = '0;
            chk_lo_d   = '0;
            sum_d      = mix_byte(seed_q, rx_byte_i);
            deadline_d = (timeout_q == '0) ? 8'd1 : timeout_q;
            phase_d    = PH_LEN;
          end
        endcase
      end

      if (fail) begin
        res_valid  = 1'b1;
        res.reply  = NakByte;
        res.last   = 1'b1;
        if (fail_next > {1'b0, retry_q}) begin
          fail_d = '0;
          res.ev = EvGiveUp;
        end else begin
          fail_d = fail_next[RtyW-1:0];
          res.ev = EvRetry;
        end
        phase_d    = PH_KIND;
        deadline_d = '0;
        sum_d      = seed_q;
      end
    end

    out_valid_d = res_valid || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      timeout_q   <= TimeoutReset;
      retry_q     <= RetryReset;
      phase_q     <= PH_KIND;
      sum_q       <= SeedReset;
      kind_q      <= '0;
      len_q       <= '0;
      ofs_lo_q    <= '0;
      count_q     <= '0;
      chk_lo_q    <= '0;
      fail_q      <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSeed:    seed_q    <= cfg_data_i[SumW-1:0];
          RegTimeout: timeout_q <= cfg_data_i[TmoW-1:0];
          RegRetry:   retry_q   <= cfg_data_i[RtyW-1:0];
          default:    ;
        endcase
      end
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      ofs_lo_q    <= ofs_lo_d;
      count_q     <= count_d;
      chk_lo_q    <= chk_lo_d;
      fail_q      <= fail_d;
      deadline_q  <= deadline_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = out_q.ev;
  assign packet_kind_o    = out_q.kind;
  assign payload_length_o = out_q.len;
  assign frame_offset_o   = out_q.ofs;
  assign byte_index_o     = out_q.idx;
  assign payload_byte_o   = out_q.val;
  assign reply_byte_o     = out_q.reply;
  assign last_o           = out_q.last;

  // timer runs exactly while a frame is open
  `FRC_ASSERT(a_deadline_in_frame, (phase_q == PH_KIND) == (deadline_q == '0), "deadline/phase mismatch")
  `FRC_ASSERT_IMP(a_last_event, out_valid_o, last_o == (event_res_o == EvAccept || event_res_o == EvRetry || event_res_o == EvGiveUp), "last flag does not match event")
  `FRC_ASSERT_IMP(a_reply_ack, out_valid_o && last_o, (reply_byte_o == AckByte) == (event_res_o == EvAccept), "reply byte does not match event")
  `FRC_ASSERT_IMP(a_result_taken, in_accept && res_valid, ##1 out_valid_o, "result lost")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the frame receiver: framed traffic, timeouts and retry handling.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import frc_pkg::*;

  localparam int  ClkHalf      = 5;
  localparam int  ResetCycles  = 7;
  localparam int  SettleCycles = 8;
  localparam int  QuietLimit   = 1000;
  localparam int  PhaseWords   = 40;
  localparam logic ActByte     = 1'b0;
  localparam logic ActTick     = 1'b1;

  typedef enum logic [2:0] {
    AwaitKind, AwaitLength, AwaitOffsLo, AwaitOffsHi, AwaitPayload, AwaitCheckLo, AwaitCheckHi
  } rx_phase_e;

  typedef struct {
    logic       act;
    logic [7:0] rx;
  } rx_word_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  kind;
    logic [7:0]  len;
    logic [15:0] ofs;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [7:0]  reply;
    logic        lst;
  } rx_result_t;

  typedef logic [7:0] byte_list_t [$];

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                action_i   = 1'b0;
  logic [ByteW-1:0]    rx_byte_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [EvW-1:0]      event_res_o;
  logic [ByteW-1:0]    packet_kind_o;
  logic [ByteW-1:0]    payload_length_o;
  logic [SumW-1:0]     frame_offset_o;
  logic [ByteW-1:0]    byte_index_o;
  logic [ByteW-1:0]    payload_byte_o;
  logic [ByteW-1:0]    reply_byte_o;
  logic                last_o;

  frame_receiver_with_checksum_top uut (.*);

  always #(ClkHalf) clk_i = ~clk_i;

  // receiver state as predicted
  logic [15:0] seed_cfg    = SeedReset;
  logic [7:0]  timeout_cfg = TimeoutReset;
  logic [3:0]  retry_cfg   = RetryReset;
  rx_phase_e   rx_phase    = AwaitKind;
  logic [15:0] run_sum     = SeedReset;
  logic [7:0]  kind_held, length_held, offs_lo_held, payload_count, check_lo_held;
  logic [3:0]  failures;
  logic [7:0]  deadline_left;

  rx_word_t   word_q [$];
  rx_result_t expected_q [$];
  int mismatches = 0;
  int stim_words = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    kind_held = '0; length_held = '0; offs_lo_held = '0; payload_count = '0;
    check_lo_held = '0; failures = '0; deadline_left = '0;
  end

  function automatic logic [15:0] fold_in(logic [15:0] s, logic [7:0] b);
    return {s[14:0], s[15]} + {8'h00, b};
  endfunction

  function automatic rx_result_t failure_result();
    rx_result_t r;
    r = '{default: '0};
    if (int'(failures) + 1 > int'(retry_cfg)) begin
      failures = '0;
      r.ev = EvGiveUp;
    end else begin
      failures = failures + 4'd1;
      r.ev = EvRetry;
    end
    r.reply = NakByte;
    r.lst = 1'b1;
    rx_phase = AwaitKind;
    deadline_left = '0;
    run_sum = seed_cfg;
    return r;
  endfunction

  task automatic step_receiver(input logic act, input logic [7:0] b);
    rx_result_t r;
    logic hit;
    r = '{default: '0};
    hit = 1'b0;
    if (act == ActTick) begin
      if (rx_phase != AwaitKind) begin
        if (deadline_left != 0) deadline_left = deadline_left - 8'd1;
        if (deadline_left == 0) begin
          r = failure_result();
          hit = 1'b1;
        end
      end
    end else begin
      case (rx_phase)
        AwaitLength: begin
          length_held = b;
          run_sum = fold_in(run_sum, b);
          rx_phase = AwaitOffsLo;
        end
        AwaitOffsLo: begin
          offs_lo_held = b;
          run_sum = fold_in(run_sum, b);
          rx_phase = AwaitOffsHi;
        end
        AwaitOffsHi: begin
          run_sum = fold_in(run_sum, b);
          payload_count = '0;
          rx_phase = (length_held == 0) ? AwaitCheckLo : AwaitPayload;
          r.ev = EvHeader;
          r.ofs = {b, offs_lo_held};
          hit = 1'b1;
        end
        AwaitPayload: begin
          r.ev = EvPayload;
          r.idx = payload_count;
          r.val = b;
          run_sum = fold_in(run_sum, b);
          payload_count = payload_count + 8'd1;
          if (payload_count >= length_held) rx_phase = AwaitCheckLo;
          hit = 1'b1;
        end
        AwaitCheckLo: begin
          check_lo_held = b;
          rx_phase = AwaitCheckHi;
        end
        AwaitCheckHi: begin
          if (deadline_left != 0 && {b, check_lo_held} == run_sum) begin
            failures = '0;
            r.ev = EvAccept;
            r.reply = AckByte;
            r.lst = 1'b1;
            rx_phase = AwaitKind;
            deadline_left = '0;
            run_sum = seed_cfg;
          end else begin
            r = failure_result();
          end
          hit = 1'b1;
        end
        default: begin
          kind_held = b;
          length_held = '0;
          offs_lo_held = '0;
          payload_count = '0;
          check_lo_held = '0;
          run_sum = fold_in(seed_cfg, b);
          deadline_left = (timeout_cfg == 0) ? 8'd1 : timeout_cfg;
          rx_phase = AwaitLength;
        end
      endcase
    end
    if (hit) begin
      r.kind = kind_held;
      r.len = length_held;
      expected_q.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // sender side
  always @(posedge clk_i) begin : drive
    rx_word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) step_receiver(action_i, rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0 && $urandom_range(99) < send_pct) begin
          send_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= w.act;
          rx_byte_i <= w.rx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin : observe
    rx_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: event_res %0d", event_res_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_res", want.ev, event_res_o);
          check_field("packet_kind", want.kind, packet_kind_o);
          check_field("payload_length", want.len, payload_length_o);
          check_field("frame_offset", want.ofs, frame_offset_o);
          check_field("byte_index", want.idx, byte_index_o);
          check_field("payload_byte", want.val, payload_byte_o);
          check_field("reply_byte", want.reply, reply_byte_o);
          check_field("last", want.lst, last_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $error("no word moved for %0d cycles", QuietLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_word(input logic act, input logic [7:0] b);
    word_q.push_back('{act, b});
    stim_words++;
  endtask

  task automatic build_frame(input logic [7:0] kind, input int len, input logic [15:0] ofs,
                             input bit corrupt, output byte_list_t fb);
    logic [15:0] s;
    fb = {};
    fb.push_back(kind);
    fb.push_back(8'(len));
    fb.push_back(ofs[7:0]);
    fb.push_back(ofs[15:8]);
    repeat (len) fb.push_back(8'($urandom));
    s = seed_cfg;
    foreach (fb[i]) s = fold_in(s, fb[i]);
    if (corrupt) s = s ^ 16'(1 << $urandom_range(15));
    fb.push_back(s[7:0]);
    fb.push_back(s[15:8]);
  endtask

  // ticks land after randomly chosen bytes of the frame
  task automatic send_bytes(input byte_list_t fb, input int ticks);
    int at [$];
    repeat (ticks) at.push_back($urandom_range(0, fb.size() - 1));
    foreach (fb[i]) begin
      push_word(ActByte, fb[i]);
      foreach (at[t]) if (at[t] == i) push_word(ActTick, 8'($urandom));
    end
  endtask

  // with a short deadline, a run of ticks always brings the receiver back to idle
  task automatic random_frame();
    byte_list_t fb;
    int len, ticks, tmo_eff;
    bit cut, tight;
    tmo_eff = (timeout_cfg == 0) ? 1 : timeout_cfg;
    tight = (tmo_eff <= 16);
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    build_frame(8'($urandom), len, 16'($urandom), $urandom_range(4) == 0, fb);
    cut = tight && $urandom_range(9) == 0;
    if (cut) repeat ($urandom_range(1, 3)) void'(fb.pop_back());
    ticks = $urandom_range(0, tight ? tmo_eff : 3);
    send_bytes(fb, ticks);
    if (cut || ticks >= tmo_eff) repeat (tmo_eff) push_word(ActTick, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      if (tight) begin
        repeat ($urandom_range(1, 3)) push_word(ActByte, 8'($urandom));
        repeat (tmo_eff) push_word(ActTick, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) push_word(ActTick, 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegSeed:    seed_cfg = val;
      RegTimeout: timeout_cfg = val[7:0];
      RegRetry:   retry_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] seed, input logic [7:0] tmo, input logic [3:0] rty,
                           input int gap_pct, input int hold_pct, input bit with_long);
    byte_list_t fb;
    int start;
    wait_drained();
    write_reg(RegSeed, seed);
    write_reg(RegTimeout, {8'($urandom), tmo});
    write_reg(RegRetry, {12'($urandom), rty});
    send_pct = gap_pct;
    stall_pct = hold_pct;
    if (with_long) begin
      build_frame(8'($urandom), 255, 16'($urandom), 1'b0, fb);
      send_bytes(fb, 2);
    end
    start = stim_words;
    while (stim_words - start < PhaseWords) random_frame();
  endtask

  initial begin
    byte_list_t fb;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pct = 30;
    stall_pct = 30;
    push_word(ActTick, 8'hFF);
    build_frame(8'h00, 0, 16'hFFFF, 1'b0, fb);
    send_bytes(fb, 0);
    build_frame(8'hFF, 1, 16'h0000, 1'b1, fb);
    send_bytes(fb, 0);
    wait_drained();

    // zero timeout and no retries: a single tick abandons the frame
    write_reg(RegSeed, 16'h0000);
    write_reg(RegTimeout, 16'h0000);
    write_reg(RegRetry, 16'h0000);
    build_frame(8'h80, 255, 16'h0100, 1'b0, fb);
    send_bytes(fb[0:4], 0);
    push_word(ActTick, 8'h00);
    wait_drained();

    // registers change inside a frame
    build_frame(8'h7E, 1, 16'h8001, 1'b0, fb);
    send_bytes(fb[0:1], 0);
    wait_drained();
    write_reg(RegSeed, 16'hFFFF);
    write_reg(RegTimeout, 16'h00FF);
    write_reg(RegRetry, 16'h000F);
    send_bytes(fb[2:$], 0);

    run_phase(16'hFFFF, 8'd255, 4'd15, 25, 25, 1'b1);
    run_phase(16'($urandom), 8'd1, 4'd0, 10, 40, 1'b0);
    run_phase(16'($urandom), 8'd4, 4'($urandom_range(1, 3)), 40, 10, 1'b0);
    run_phase(16'h0000, 8'd10, 4'd2, 0, 0, 1'b0);
    run_phase(16'($urandom), 8'($urandom_range(20, 200)), 4'($urandom), 20, 20, 1'b0);
    run_phase(16'($urandom), 8'd64, 4'd5, 0, 0, 1'b0);
    wait_drained();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== frame_receiver_with_checksum_top.f =====
+incdir+sv
sv/frc_pkg.sv
sv/frame_receiver_with_checksum_top.sv
verif/testbench.sv
